FILE: hdl/nrmc_pkg.sv
// Shared types, constants and functions of the RMC sentence parser.
package nrmc_pkg;

    localparam int          MAX_SENTENCE_DEF    = 80;
    localparam int          POS_FRAC_DIGITS_DEF = 5;
    localparam int          SPEED_FRAC_DIGITS   = 3;

    localparam int          LAT_W   = 30;
    localparam int          LON_W   = 31;
    localparam int          SPEED_W = 20;
    localparam int unsigned LAT_MAX   = 32'd900000000;
    localparam int unsigned LON_MAX   = 32'd1800000000;
    localparam int unsigned SPEED_MAX = 32'd999999;

    localparam logic [6:0]  HDR_LEN  = 7'd7;
    localparam logic [2:0]  HDR_LAST = 3'd6;

    localparam logic [7:0]  CH_DOLLAR = 8'h24;
    localparam logic [7:0]  CH_STAR   = 8'h2A;
    localparam logic [7:0]  CH_COMMA  = 8'h2C;
    localparam logic [7:0]  CH_POINT  = 8'h2E;
    localparam logic [7:0]  CH_ZERO   = 8'h30;
    localparam logic [7:0]  CH_NINE   = 8'h39;
    localparam logic [7:0]  CH_A      = 8'h41;
    localparam logic [7:0]  CH_N      = 8'h4E;
    localparam logic [7:0]  CH_E      = 8'h45;

    localparam logic [2:0]  FLD_STATUS = 3'd1;
    localparam logic [2:0]  FLD_LAT    = 3'd2;
    localparam logic [2:0]  FLD_NS     = 3'd3;
    localparam logic [2:0]  FLD_LON    = 3'd4;
    localparam logic [2:0]  FLD_EW     = 3'd5;
    localparam logic [2:0]  FLD_SPEED  = 3'd6;
    localparam logic [2:0]  FLD_LAST   = 3'd7;
    localparam logic [2:0]  CNT_MAX    = 3'd7;

    // Per-item control for one numeric field accumulator
    typedef struct packed {
        logic       clr;
        logic       mac;
        logic       close;
        logic [3:0] digit;
    } t_num_ctl;

    function automatic logic [7:0] hdr_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = CH_DOLLAR;
            3'd1:    ch = 8'h47;  // G
            3'd2:    ch = 8'h50;  // P
            3'd3:    ch = 8'h52;  // R
            3'd4:    ch = 8'h4D;  // M
            3'd5:    ch = 8'h43;  // C
            3'd6:    ch = CH_COMMA;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [16:0] pow10(input logic [2:0] k);
        logic [16:0] p;
        case (k)
            3'd0:    p = 17'd1;
            3'd1:    p = 17'd10;
            3'd2:    p = 17'd100;
            3'd3:    p = 17'd1000;
            3'd4:    p = 17'd10000;
            3'd5:    p = 17'd100000;
            default: p = 17'd1;
        endcase
        return p;
    endfunction

endpackage

FILE: hdl/nrmc_num.sv
// Saturating decimal-to-binary accumulator for one numeric field.
module nrmc_num
    import nrmc_pkg::*;
#(
    parameter int          W      = LAT_W,
    parameter int unsigned LIM    = LAT_MAX,
    parameter int          DIGITS = POS_FRAC_DIGITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  t_num_ctl     i_ctl,
    input  logic [2:0]   i_frac_cnt,
    output logic [W-1:0] o_mag,
    output logic [W-1:0] o_mag_next
);

    localparam int         PW  = W + 18;
    localparam logic [2:0] DIG = 3'(DIGITS);

    logic [W-1:0]  r_mag;
    logic [W-1:0]  n_mag;
    logic [16:0]   mult;
    logic [PW-1:0] prod;

    always_comb begin
        mult = i_ctl.mac ? 17'd10 : pow10(DIG - i_frac_cnt);
        prod = PW'(r_mag) * PW'(mult) + PW'(i_ctl.mac ? i_ctl.digit : 4'd0);
        n_mag = r_mag;
        if (i_ctl.clr) begin
            n_mag = '0;
        end else if (i_ctl.mac || i_ctl.close) begin
            n_mag = (prod > PW'(LIM)) ? W'(LIM) : prod[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mag <= '0;
        end else if (i_en) begin
            r_mag <= n_mag;
        end
    end

    assign o_mag      = r_mag;
    assign o_mag_next = n_mag;

`ifndef NO_ASSERTIONS
    a_mag_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mag <= W'(LIM))
        else $error("field magnitude above limit");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_ctl.clr) |=> (r_mag == '0))
        else $error("field magnitude not cleared");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> $stable(r_mag))
        else $error("field magnitude changed without an item");
`endif

endmodule

FILE: hdl/nmea_rmc_sentence_parser.sv
// Top level of the RMC sentence parser: header hunt, field split and result register.
//
//  channel | valid   | ready   | payload
//  --------+---------+---------+------------------------------------------
//  in      | i_valid | o_ready | i_rx_byte
//  out     | o_valid | i_ready | o_latitude, o_longitude, o_ground_speed
//
// One byte is taken per cycle while o_ready is high; its result, if any, is shown the next cycle.
// The state update is one pass: header compare, then a 10x or 10^k multiply-add per field.
// A result waiting in the output register does not stop intake unless it is not taken.
// Synchronous active-low reset; the block hunts for a header after reset.
module nmea_rmc_sentence_parser
    import nrmc_pkg::*;
#(
    parameter int MAX_SENTENCE    = MAX_SENTENCE_DEF,
    parameter int POS_FRAC_DIGITS = POS_FRAC_DIGITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_rx_byte,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [30:0] o_latitude,
    output logic signed [31:0] o_longitude,
    output logic [19:0]        o_ground_speed
);

    localparam logic [6:0] MAX_BYTES = 7'(MAX_SENTENCE);
    localparam logic [2:0] POS_DIG   = 3'(POS_FRAC_DIGITS);
    localparam logic [2:0] SPD_DIG   = 3'(SPEED_FRAC_DIGITS);

    logic [2:0] r_hdr_pos,    n_hdr_pos;
    logic       r_in_body,    n_in_body;
    logic [2:0] r_field_idx,  n_field_idx;
    logic [6:0] r_byte_cnt,   n_byte_cnt;
    logic       r_status_ok,  n_status_ok;
    logic       r_north,      n_north;
    logic       r_east,       n_east;
    logic       r_seen_point, n_seen_point;
    logic [2:0] r_frac_cnt,   n_frac_cnt;

    logic               r_out_valid;
    logic signed [30:0] r_latitude;
    logic signed [31:0] r_longitude;
    logic [19:0]        r_speed;

    logic         in_acc;
    logic         emit;
    logic         is_digit;
    logic [3:0]   digit_raw;
    t_num_ctl     lat_ctl, lon_ctl, spd_ctl;
    logic [LAT_W-1:0]   lat_mag, lat_next;
    logic [LON_W-1:0]   lon_mag, lon_next;
    logic [SPEED_W-1:0] spd_mag, spd_next;

    assign o_ready   = !r_out_valid || i_ready;
    assign in_acc    = i_valid && o_ready;
    assign digit_raw = 4'(i_rx_byte - CH_ZERO);
    assign is_digit  = (i_rx_byte >= CH_ZERO) && (i_rx_byte <= CH_NINE);

    always_comb begin
        n_hdr_pos    = r_hdr_pos;
        n_in_body    = r_in_body;
        n_field_idx  = r_field_idx;
        n_byte_cnt   = r_byte_cnt;
        n_status_ok  = r_status_ok;
        n_north      = r_north;
        n_east       = r_east;
        n_seen_point = r_seen_point;
        n_frac_cnt   = r_frac_cnt;
        lat_ctl      = '{clr: 1'b0, mac: 1'b0, close: 1'b0, digit: digit_raw};
        lon_ctl      = lat_ctl;
        spd_ctl      = lat_ctl;
        emit         = 1'b0;
        if (in_acc) begin
            if (i_rx_byte == CH_DOLLAR) begin
                n_in_body = 1'b0;
                n_hdr_pos = 3'd1;
            end else if (!r_in_body) begin
                if (i_rx_byte == hdr_char(r_hdr_pos)) begin
                    if (r_hdr_pos == HDR_LAST) begin
                        n_in_body    = 1'b1;
                        n_hdr_pos    = '0;
                        n_field_idx  = '0;
                        n_byte_cnt   = HDR_LEN;
                        n_status_ok  = 1'b0;
                        n_north      = 1'b0;
                        n_east       = 1'b0;
                        n_seen_point = 1'b0;
                        n_frac_cnt   = '0;
                        lat_ctl.clr  = 1'b1;
                        lon_ctl.clr  = 1'b1;
                        spd_ctl.clr  = 1'b1;
                    end else begin
                        n_hdr_pos = r_hdr_pos + 3'd1;
                    end
                end else begin
                    n_hdr_pos = '0;
                end
            end else if (r_byte_cnt >= MAX_BYTES) begin
                // over-long sentence: drop it
                n_in_body = 1'b0;
                n_hdr_pos = '0;
            end else begin
                n_byte_cnt = r_byte_cnt + 7'd1;
                if (i_rx_byte == CH_STAR || i_rx_byte == CH_COMMA) begin
                    lat_ctl.close = (r_field_idx == FLD_LAT);
                    lon_ctl.close = (r_field_idx == FLD_LON);
                    spd_ctl.close = (r_field_idx == FLD_SPEED);
                    n_seen_point  = 1'b0;
                    n_frac_cnt    = '0;
                    if (i_rx_byte == CH_STAR) begin
                        n_in_body = 1'b0;
                        n_hdr_pos = '0;
                        emit      = r_status_ok;
                    end else if (r_field_idx != FLD_LAST) begin
                        n_field_idx = r_field_idx + 3'd1;
                    end
                end else begin
                    case (r_field_idx)
                        FLD_STATUS, FLD_NS, FLD_EW: begin
                            if (r_field_idx == FLD_STATUS) begin
                                n_status_ok = (r_frac_cnt == '0) && (i_rx_byte == CH_A);
                            end else if (r_field_idx == FLD_NS) begin
                                n_north = (r_frac_cnt == '0) && (i_rx_byte == CH_N);
                            end else begin
                                n_east = (r_frac_cnt == '0) && (i_rx_byte == CH_E);
                            end
                            if (r_frac_cnt != CNT_MAX) begin
                                n_frac_cnt = r_frac_cnt + 3'd1;
                            end
                        end
                        FLD_LAT, FLD_LON, FLD_SPEED: begin
                            if (is_digit) begin
                                if (!r_seen_point) begin
                                    lat_ctl.mac = (r_field_idx == FLD_LAT);
                                    lon_ctl.mac = (r_field_idx == FLD_LON);
                                    spd_ctl.mac = (r_field_idx == FLD_SPEED);
                                end else if (r_frac_cnt <
                                        ((r_field_idx == FLD_SPEED) ? SPD_DIG : POS_DIG)) begin
                                    lat_ctl.mac = (r_field_idx == FLD_LAT);
                                    lon_ctl.mac = (r_field_idx == FLD_LON);
                                    spd_ctl.mac = (r_field_idx == FLD_SPEED);
                                    n_frac_cnt  = r_frac_cnt + 3'd1;
                                end
                            end else if (i_rx_byte == CH_POINT) begin
                                n_seen_point = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
        end
    end

    nrmc_num #(
        .W(LAT_W), .LIM(LAT_MAX), .DIGITS(POS_FRAC_DIGITS)
    ) u_lat (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(in_acc), .i_ctl(lat_ctl),
        .i_frac_cnt(r_frac_cnt), .o_mag(lat_mag), .o_mag_next(lat_next)
    );

    nrmc_num #(
        .W(LON_W), .LIM(LON_MAX), .DIGITS(POS_FRAC_DIGITS)
    ) u_lon (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(in_acc), .i_ctl(lon_ctl),
        .i_frac_cnt(r_frac_cnt), .o_mag(lon_mag), .o_mag_next(lon_next)
    );

    nrmc_num #(
        .W(SPEED_W), .LIM(SPEED_MAX), .DIGITS(SPEED_FRAC_DIGITS)
    ) u_spd (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(in_acc), .i_ctl(spd_ctl),
        .i_frac_cnt(r_frac_cnt), .o_mag(spd_mag), .o_mag_next(spd_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_pos    <= '0;
            r_in_body    <= 1'b0;
            r_field_idx  <= '0;
            r_byte_cnt   <= '0;
            r_status_ok  <= 1'b0;
            r_north      <= 1'b0;
            r_east       <= 1'b0;
            r_seen_point <= 1'b0;
            r_frac_cnt   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_hdr_pos    <= n_hdr_pos;
            r_in_body    <= n_in_body;
            r_field_idx  <= n_field_idx;
            r_byte_cnt   <= n_byte_cnt;
            r_status_ok  <= n_status_ok;
            r_north      <= n_north;
            r_east       <= n_east;
            r_seen_point <= n_seen_point;
            r_frac_cnt   <= n_frac_cnt;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_latitude  <= r_north ? signed'({1'b0, lat_next}) : -signed'({1'b0, lat_next});
            r_longitude <= r_east ? signed'({1'b0, lon_next}) : -signed'({1'b0, lon_next});
            r_speed     <= spd_next;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_latitude     = r_latitude;
    assign o_longitude    = r_longitude;
    assign o_ground_speed = r_speed;

`ifndef NO_ASSERTIONS
    a_result_at_star: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(in_acc && i_rx_byte == CH_STAR && r_status_ok))
        else $error("result without a closing star");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_body |-> (r_byte_cnt <= MAX_BYTES && r_hdr_pos == '0))
        else $error("body state out of bounds");

    a_no_accept_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |-> !o_ready)
        else $error("item taken while result stalled");

    a_mags_quiet_in_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_in_body && in_acc && i_rx_byte != CH_DOLLAR && r_hdr_pos != HDR_LAST)
            |=> ($stable(lat_mag) && $stable(lon_mag) && $stable(spd_mag)))
        else $error("field state changed during header hunt");
`endif

endmodule

FILE: test/nmea_rmc_sentence_parser_tb.sv
// Testbench of the RMC sentence parser: byte-level predictor, directed and random sentences.
`timescale 1ns / 100ps

module nmea_rmc_sentence_parser_tb;
    import nrmc_pkg::*;

    localparam int          CYCLE_LIMIT = 500000;
    localparam int          HOLD_CYCLES = 400;
    localparam logic [55:0] RMC_TAG     = "$GPRMC,";
    localparam logic [7:0]  CH_V        = 8'h56;
    localparam logic [7:0]  CH_S        = 8'h53;
    localparam logic [7:0]  CH_W        = 8'h57;

    typedef struct packed {
        logic signed [30:0] lat;
        logic signed [31:0] lon;
        logic [19:0]        speed;
    } t_rmc_fix;

    logic               i_clk     = 1'b0;
    logic               i_rst_n   = 1'b0;
    logic               i_valid   = 1'b0;
    logic [7:0]         i_rx_byte = 8'h00;
    logic               i_ready   = 1'b0;
    logic               o_ready;
    logic               o_valid;
    logic signed [30:0] o_latitude;
    logic signed [31:0] o_longitude;
    logic [19:0]        o_ground_speed;

    // predictor state
    logic [2:0]         hdr_pos  = '0;
    bit                 in_body  = 1'b0;
    logic [2:0]         fld      = '0;
    logic [6:0]         nbytes   = '0;
    bit                 stat_a   = 1'b0;
    bit                 north    = 1'b0;
    bit                 east     = 1'b0;
    logic [LAT_W-1:0]   lat_mag  = '0;
    logic [LON_W-1:0]   lon_mag  = '0;
    logic [SPEED_W-1:0] spd_mag  = '0;
    bit                 got_point = 1'b0;
    logic [2:0]         frac_n   = '0;

    t_rmc_fix   fix_queue[$];
    logic [7:0] line_buf[$];
    int         fixes_due     = 0;
    int         items_sent    = 0;
    int         mismatches    = 0;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    int         hold_asks     = 0;
    int         hold_done     = 0;
    int         hold_left     = 0;
    int         cycle_count   = 0;

    nmea_rmc_sentence_parser dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_latitude     (o_latitude),
        .o_longitude    (o_longitude),
        .o_ground_speed (o_ground_speed)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ---------------- predictor ----------------

    function automatic logic [31:0] ten_x_add(input logic [31:0] v, input logic [3:0] d,
                                              input logic [31:0] lim);
        logic [63:0] r;
        r = 64'(v) * 64'd10 + 64'(d);
        return (r > 64'(lim)) ? lim : r[31:0];
    endfunction

    task automatic number_byte(inout logic [31:0] mag, input logic [31:0] lim,
                               input int scale, input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) begin
            if (!got_point) begin
                mag = ten_x_add(mag, c[3:0], lim);
            end else if (int'(frac_n) < scale) begin
                mag = ten_x_add(mag, c[3:0], lim);
                frac_n++;
            end
        end else if (c == CH_POINT) begin
            got_point = 1'b1;
        end
    endtask

    task automatic flag_byte(inout bit flag, input logic [7:0] want, input logic [7:0] c);
        flag = (frac_n == 3'd0) && (c == want);
        if (frac_n != CNT_MAX) frac_n++;
    endtask

    // pad missing fraction digits with zeros
    task automatic close_field();
        logic [31:0] m;
        int          k;
        case (fld)
            FLD_LAT: begin
                m = 32'(lat_mag);
                for (k = int'(frac_n); k < POS_FRAC_DIGITS_DEF; k++)
                    m = ten_x_add(m, 4'd0, LAT_MAX);
                lat_mag = m[LAT_W-1:0];
            end
            FLD_LON: begin
                m = 32'(lon_mag);
                for (k = int'(frac_n); k < POS_FRAC_DIGITS_DEF; k++)
                    m = ten_x_add(m, 4'd0, LON_MAX);
                lon_mag = m[LON_W-1:0];
            end
            FLD_SPEED: begin
                m = 32'(spd_mag);
                for (k = int'(frac_n); k < SPEED_FRAC_DIGITS; k++)
                    m = ten_x_add(m, 4'd0, SPEED_MAX);
                spd_mag = m[SPEED_W-1:0];
            end
            default: ;
        endcase
        got_point = 1'b0;
        frac_n    = '0;
    endtask

    task automatic predict_rmc_byte(input logic [7:0] c);
        t_rmc_fix    fix;
        logic [31:0] m;
        if (c == CH_DOLLAR) begin
            in_body = 1'b0;
            hdr_pos = 3'd1;
        end else if (!in_body) begin
            if (c == RMC_TAG[8*(6 - int'(hdr_pos)) +: 8]) begin
                if (hdr_pos == HDR_LAST) begin
                    in_body = 1'b1;  hdr_pos = '0;  fld = '0;  nbytes = HDR_LEN;
                    stat_a  = 1'b0;  north = 1'b0;  east = 1'b0;
                    lat_mag = '0;    lon_mag = '0;  spd_mag = '0;
                    got_point = 1'b0;  frac_n = '0;
                end else begin
                    hdr_pos++;
                end
            end else begin
                hdr_pos = '0;
            end
        end else if (int'(nbytes) + 1 > MAX_SENTENCE_DEF) begin
            in_body = 1'b0;
            hdr_pos = '0;
        end else begin
            nbytes++;
            if (c == CH_STAR) begin
                close_field();
                in_body = 1'b0;
                hdr_pos = '0;
                if (stat_a) begin
                    fix.lat   = north ? 31'(lat_mag) : -31'(lat_mag);
                    fix.lon   = east ? 32'(lon_mag) : -32'(lon_mag);
                    fix.speed = spd_mag;
                    fix_queue.push_back(fix);
                    fixes_due++;
                end
            end else if (c == CH_COMMA) begin
                close_field();
                if (fld != FLD_LAST) fld++;
            end else begin
                case (fld)
                    FLD_STATUS: flag_byte(stat_a, CH_A, c);
                    FLD_NS:     flag_byte(north, CH_N, c);
                    FLD_EW:     flag_byte(east, CH_E, c);
                    FLD_LAT: begin
                        m = 32'(lat_mag);
                        number_byte(m, LAT_MAX, POS_FRAC_DIGITS_DEF, c);
                        lat_mag = m[LAT_W-1:0];
                    end
                    FLD_LON: begin
                        m = 32'(lon_mag);
                        number_byte(m, LON_MAX, POS_FRAC_DIGITS_DEF, c);
                        lon_mag = m[LON_W-1:0];
                    end
                    FLD_SPEED: begin
                        m = 32'(spd_mag);
                        number_byte(m, SPEED_MAX, SPEED_FRAC_DIGITS, c);
                        spd_mag = m[SPEED_W-1:0];
                    end
                    default: ;
                endcase
            end
        end
    endtask

    // ---------------- checking ----------------

    task automatic report_mismatch(input string what);
        $display("mismatch @%0d: %s", cycle_count, what);
        mismatches++;
    endtask

    always @(posedge i_clk) begin : check_fixes
        t_rmc_fix want;
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            if (fix_queue.size() == 0) begin
                report_mismatch("result with none expected");
            end else begin
                want = fix_queue.pop_front();
                if (o_latitude !== want.lat)
                    report_mismatch($sformatf("latitude %0d, want %0d", o_latitude, want.lat));
                if (o_longitude !== want.lon)
                    report_mismatch($sformatf("longitude %0d, want %0d", o_longitude, want.lon));
                if (o_ground_speed !== want.speed)
                    report_mismatch($sformatf("speed %0d, want %0d", o_ground_speed, want.speed));
            end
        end
    end

    // receiver: random stalls, plus long hold-offs on request
    always @(posedge i_clk) begin
        if (hold_asks != hold_done) begin
            hold_done <= hold_done + 1;
            hold_left <= HOLD_CYCLES;
            i_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // ---------------- stimulus ----------------

    task automatic send_byte(input logic [7:0] c);
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= c;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_rmc_byte(c);
    endtask

    task automatic send_line();
        foreach (line_buf[i]) send_byte(line_buf[i]);
        line_buf.delete();
    endtask

    task automatic drain_fixes();
        i_valid <= 1'b0;
        while (fix_queue.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic void put_text(input string s);
        for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    endfunction

    function automatic void put_digits(input int n);
        repeat (n) line_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        if (c == CH_DOLLAR || c == CH_STAR || c == CH_COMMA) c = CH_POINT;
        return c;
    endfunction

    function automatic void put_number(input int max_int, input bit clean);
        put_digits($urandom_range(0, max_int));
        if ($urandom_range(0, 7) != 0) begin
            line_buf.push_back(CH_POINT);
            put_digits($urandom_range(0, 7));
        end
        if (!clean) begin
            case ($urandom_range(0, 11))
                0: begin line_buf.push_back(CH_POINT); put_digits(2); end
                1: begin line_buf.push_back(plain_byte()); put_digits(1); end
                default: ;
            endcase
        end
    endfunction

    function automatic void put_flag(input logic [7:0] want, input logic [7:0] other,
                                     input bit clean);
        case (clean ? 9 : $urandom_range(0, 9))
            0: ;
            1: line_buf.push_back(other);
            2: begin line_buf.push_back(want); line_buf.push_back(want); end
            3: line_buf.push_back(plain_byte());
            4: begin line_buf.push_back(other); line_buf.push_back(want); end
            default: line_buf.push_back(want);
        endcase
    endfunction

    function automatic void put_sentence(input bit clean);
        int last_fld;
        if (!clean && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 6)) line_buf.push_back(8'($urandom_range(0, 255)));
        if (!clean && $urandom_range(0, 9) == 0) begin
            if ($urandom_range(0, 1) != 0) put_text("$GP");
            else put_text("$GPRMC,12");
        end
        case (clean ? 2 : $urandom_range(0, 15))
            0:       put_text("$GPGGA,");
            1:       put_text("$GPRMX,");
            default: put_text("$GPRMC,");
        endcase
        last_fld = (!clean && $urandom_range(0, 9) == 0) ? $urandom_range(1, 5) : 6;
        for (int f = 0; f <= last_fld; f++) begin
            if (f != 0) line_buf.push_back(CH_COMMA);
            case (f)
                0: put_digits($urandom_range(0, 6));
                1: put_flag(CH_A, CH_V, clean);
                2: put_number($urandom_range(0, 7) == 0 ? 10 : 4, clean);
                3: put_flag(CH_N, CH_S, 1'b0);
                4: put_number($urandom_range(0, 7) == 0 ? 11 : 5, clean);
                5: put_flag(CH_E, CH_W, 1'b0);
                default: put_number($urandom_range(0, 7) == 0 ? 7 : 3, clean);
            endcase
        end
        repeat ($urandom_range(0, 4)) begin
            line_buf.push_back(CH_COMMA);
            put_digits($urandom_range(0, 6));
        end
        if (!clean && $urandom_range(0, 19) == 0)
            repeat (40) line_buf.push_back(plain_byte());
        if (!clean && $urandom_range(0, 11) == 0)
            line_buf.push_back(CH_DOLLAR);
        if (clean || $urandom_range(0, 15) != 0)
            line_buf.push_back(CH_STAR);
        items_sent += line_buf.size();
        put_text($sformatf("%02X\r\n", $urandom_range(0, 255)));
    endfunction

    // ---------------- tests ----------------

    task automatic test_field_extremes();
        put_text("$GPRMC,,A,9000.00000,N,18000.00000,E,999.999*");
        put_text("$GPRMC,,A,,S,,W,*");
        put_text("$GPRMC,,A,99999,N,999999,E,1000*");
        send_line();
    endtask

    task automatic test_number_text();
        put_text("$GPRMC,,A,12.3456789,N,1.2.3x4,E,.5*");
        send_line();
    endtask

    task automatic test_flags_and_status();
        put_text("$GPRMC,,V,1,N,2,E,3*$GPRMC,,AA,1,N,2,E,3*$GPRMC,,A,1,NN,2,e,3*");
        send_line();
    endtask

    task automatic test_stray_dollar();
        put_text("$GPR$GPRMC,,A,1,N,2,E,3,$GPRMC,,A,5,N,6,E,7*");
        send_line();
    endtask

    task automatic test_short_sentence();
        put_text("$GPRMC,,A*$GPRMC,,A,12*");
        send_line();
    endtask

    // '*' as the last allowed byte, then one byte too many, then recovery
    task automatic test_long_sentence();
        put_text("$GPRMC,,A,1,N,2,E,3,");
        put_digits(59);
        line_buf.push_back(CH_STAR);
        put_text("$GPRMC,,A,1,N,2,E,3,");
        put_digits(60);
        put_text("*$GPRMC,,A,4,S,5,W,6*");
        send_line();
    endtask

    task automatic test_stalled_receiver();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_asks++;
        repeat (8) begin
            put_sentence(1'b1);
            send_line();
        end
        drain_fixes();
    endtask

    task automatic test_random_traffic(input int tx_pct, input int rx_pct);
        int items_goal;
        int fixes_goal;
        send_idle_pct = tx_pct;
        recv_idle_pct = rx_pct;
        items_goal    = items_sent + 260;
        fixes_goal    = fixes_due + 3;
        while (items_sent < items_goal || fixes_due < fixes_goal) begin
            put_sentence($urandom_range(0, 3) == 0);
            send_line();
        end
        drain_fixes();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_field_extremes();
        test_number_text();
        test_flags_and_status();
        test_stray_dollar();
        test_short_sentence();
        test_long_sentence();
        drain_fixes();
        test_stalled_receiver();
        test_random_traffic(20, 56);
        test_random_traffic(56, 20);
        test_random_traffic(0, 0);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/nrmc_pkg.sv
hdl/nrmc_num.sv
hdl/nmea_rmc_sentence_parser.sv
test/nmea_rmc_sentence_parser_tb.sv
